[design/bre_pkg.sv]
package bre_pkg;

	localparam int MAX_BITS    = 1024;
	localparam int WORD_BITS   = 64;
	localparam int STORE_WORDS = MAX_BITS / WORD_BITS;
	localparam int WIDX_W      = $clog2(STORE_WORDS);
	localparam int BIT_W       = $clog2(WORD_BITS);
	localparam int POS_W       = 10;
	localparam int LEN_W       = 11;
	localparam int ACT_W       = 3;
	localparam int WPOP_W      = BIT_W + 1;

	localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_BITS);
	localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1024);

	localparam logic [ACT_W-1:0] ACT_GET    = 3'd0;
	localparam logic [ACT_W-1:0] ACT_PUT    = 3'd1;
	localparam logic [ACT_W-1:0] ACT_SET    = 3'd2;
	localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd3;
	localparam logic [ACT_W-1:0] ACT_INVERT = 3'd4;
	localparam logic [ACT_W-1:0] ACT_COUNT  = 3'd5;

	localparam logic [2:0] NIB_POP [16] = '{
		3'd0, 3'd1, 3'd1, 3'd2, 3'd1, 3'd2, 3'd2, 3'd3,
		3'd1, 3'd2, 3'd2, 3'd3, 3'd2, 3'd3, 3'd3, 3'd4
	};

	typedef struct packed {
		logic load;
		logic setup;
		logic step;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic skip;
		logic last;
	} stat_t;

endpackage

[design/bre_ctrl.sv]
module bre_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  bre_pkg::stat_t stat,
	output bre_pkg::cmd_t  cmd
);
	import bre_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SETUP,
		ST_WALK,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd        = '0;
		cmd.load   = (state_q == ST_IDLE) && in_valid;
		cmd.setup  = (state_q == ST_SETUP);
		cmd.step   = (state_q == ST_WALK);
		cmd.finish = (state_q == ST_DONE) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					state_q <= stat.skip ? ST_DONE : ST_WALK;
				end
				ST_WALK: begin
					if (stat.last) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_load_to_setup: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == ST_SETUP)
		else $error("accepted request did not enter setup");
	a_finish_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_valid_q)
		else $error("finished result not presented");
	a_skip_no_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SETUP) && stat.skip |=> state_q == ST_DONE)
		else $error("rejected request walked the store");
	a_single_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.setup, cmd.step, cmd.finish}))
		else $error("more than one command issued");

endmodule

[design/bre_dp.sv]
module bre_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [bre_pkg::LEN_W-1:0]   cfg_data,
	input  logic [bre_pkg::ACT_W-1:0]   action,
	input  logic [bre_pkg::POS_W-1:0]   position,
	input  logic                        new_bit,
	input  logic [bre_pkg::POS_W-1:0]   range_low,
	input  logic [bre_pkg::POS_W-1:0]   range_high,
	input  bre_pkg::cmd_t               cmd,
	output bre_pkg::stat_t              stat,
	output logic                        read_bit,
	output logic [bre_pkg::LEN_W-1:0]   population,
	output logic                        status
);
	import bre_pkg::*;

	function automatic logic [WPOP_W-1:0] pop64(input logic [WORD_BITS-1:0] v);
		logic [2:0] l0 [16];
		logic [3:0] l1 [8];
		logic [4:0] l2 [4];
		logic [5:0] l3 [2];
		for (int i = 0; i < 16; i++) l0[i] = NIB_POP[v[4*i +: 4]];
		for (int i = 0; i < 8; i++)  l1[i] = 4'(l0[2*i]) + 4'(l0[2*i+1]);
		for (int i = 0; i < 4; i++)  l2[i] = 5'(l1[2*i]) + 5'(l1[2*i+1]);
		for (int i = 0; i < 2; i++)  l3[i] = 6'(l2[2*i]) + 6'(l2[2*i+1]);
		return 7'(l3[0]) + 7'(l3[1]);
	endfunction

	logic [ACT_W-1:0]     act_q;
	logic [POS_W-1:0]     pos_q, lo_q, hi_q;
	logic                 nbit_q;
	logic [LEN_W-1:0]     len_q, lene_q;
	logic [WIDX_W-1:0]    w_q, end_q;
	logic                 err_q, rbit_q;
	logic [LEN_W-1:0]     pop_q;
	logic [WORD_BITS-1:0] store_q [STORE_WORDS];

	logic [LEN_W-1:0]     lene, lene_m1, rem;
	logic                 is_bit, is_range, is_count, err_c;
	logic [WIDX_W-1:0]    start_c, end_c;
	logic [WORD_BITS-1:0] word, lo_m, hi_m, rmask, cmask, new_word;
	logic [BIT_W-1:0]     a_sh, b_sh;

	assign lene     = (len_q > LEN_MAX) ? LEN_MAX : len_q;
	assign lene_m1  = lene - LEN_W'(1);
	assign is_bit   = (act_q == ACT_GET) || (act_q == ACT_PUT);
	assign is_range = (act_q == ACT_SET) || (act_q == ACT_CLEAR) || (act_q == ACT_INVERT);
	assign is_count = (act_q == ACT_COUNT);

	always_comb begin
		err_c   = 1'b0;
		start_c = '0;
		end_c   = '0;
		if (is_bit) begin
			err_c   = LEN_W'(pos_q) >= lene;
			start_c = pos_q[POS_W-1 -: WIDX_W];
			end_c   = pos_q[POS_W-1 -: WIDX_W];
		end else if (is_range) begin
			err_c   = (LEN_W'(hi_q) >= lene) || (lo_q > hi_q);
			start_c = lo_q[POS_W-1 -: WIDX_W];
			end_c   = hi_q[POS_W-1 -: WIDX_W];
		end else if (is_count) begin
			end_c = lene_m1[POS_W-1 -: WIDX_W];
		end else begin
			err_c = 1'b1;
		end
	end

	assign stat.skip = err_c || (is_count && (lene == '0));
	assign stat.last = (w_q == end_q);

	assign word  = store_q[w_q];
	assign a_sh  = (w_q == lo_q[POS_W-1 -: WIDX_W]) ? lo_q[BIT_W-1:0] : '0;
	assign b_sh  = (w_q == hi_q[POS_W-1 -: WIDX_W]) ? hi_q[BIT_W-1:0] : '1;
	assign lo_m  = {WORD_BITS{1'b1}} << a_sh;
	assign hi_m  = {WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - b_sh);
	assign rmask = lo_m & hi_m;
	assign rem   = lene_q - {1'b0, w_q, {BIT_W{1'b0}}};
	assign cmask = (rem >= LEN_W'(WORD_BITS)) ? {WORD_BITS{1'b1}}
		: ~({WORD_BITS{1'b1}} << rem[BIT_W-1:0]);

	always_comb begin
		new_word = word;
		if (act_q == ACT_PUT) begin
			new_word[pos_q[BIT_W-1:0]] = nbit_q;
		end else if (act_q == ACT_SET) begin
			new_word = word | rmask;
		end else if (act_q == ACT_CLEAR) begin
			new_word = word & ~rmask;
		end else if (act_q == ACT_INVERT) begin
			new_word = word ^ rmask;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LEN_RESET;
		end else if (cfg_we) begin
			len_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STORE_WORDS; i++) store_q[i] <= '0;
		end else if (cmd.step) begin
			store_q[w_q] <= new_word;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q  <= action;
			pos_q  <= position;
			nbit_q <= new_bit;
			lo_q   <= range_low;
			hi_q   <= range_high;
			rbit_q <= 1'b0;
			pop_q  <= '0;
		end
		if (cmd.setup) begin
			lene_q <= lene;
			err_q  <= err_c;
			w_q    <= start_c;
			end_q  <= end_c;
		end
		if (cmd.step) begin
			w_q <= w_q + WIDX_W'(1);
			if (is_bit) begin
				rbit_q <= word[pos_q[BIT_W-1:0]];
			end
			if (is_count) begin
				pop_q <= pop_q + LEN_W'(pop64(word & cmask));
			end
		end
		if (cmd.finish) begin
			read_bit   <= rbit_q;
			population <= pop_q;
			status     <= err_q;
		end
	end

	a_step_no_err: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> !err_q)
		else $error("store walked for a rejected request");
	a_err_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish && err_q |-> !rbit_q && (pop_q == '0))
		else $error("rejected request carries data");
	a_pop_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish && is_count |-> pop_q <= lene_q)
		else $error("population exceeds length");

endmodule

[design/bitmap_range_engine_unit.sv]
// Bit vector of up to 1024 bits held as 16 words of 64 bits.
// Sequence: accept, setup, word walk (get/put one word; set/clear/invert/count the words
// in range, up to 16), then done. Rejected requests and count with length zero skip the walk.
// Throughput: one request at a time; the word walk (one store word per cycle) sets it.
// Reset: arst_n clears the store, idles the controller and sets the length to 1024.
module bitmap_range_engine_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [bre_pkg::ACT_W-1:0] action,
	input  logic [bre_pkg::POS_W-1:0] position,
	input  logic                      new_bit,
	input  logic [bre_pkg::POS_W-1:0] range_low,
	input  logic [bre_pkg::POS_W-1:0] range_high,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      read_bit,
	output logic [bre_pkg::LEN_W-1:0] population,
	output logic                      status,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [bre_pkg::LEN_W-1:0] cfg_data
);
	import bre_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	assign cfg_ready = 1'b1;

	bre_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	bre_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_data   (cfg_data),
		.action     (action),
		.position   (position),
		.new_bit    (new_bit),
		.range_low  (range_low),
		.range_high (range_high),
		.cmd        (cmd),
		.stat       (stat),
		.read_bit   (read_bit),
		.population (population),
		.status     (status)
	);

endmodule
